// ===== sv/rlm_pkg.sv =====
// Package for the RMS level meter: widths, micro-operation and jump codes,
// the control word type and the read-only microprogram.
// Used by every module of the block; depends on nothing.
package rlm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS;
    localparam int SUM_BITS    = 42;
    localparam int MAX_FRAME   = 4096;
    localparam int CNT_BITS    = $clog2(MAX_FRAME + 1);
    localparam int ROOT_BITS   = SUM_BITS / 2;
    localparam int SREM_BITS   = ROOT_BITS + 1;
    localparam int GAIN_BITS   = 16;
    localparam int GAIN_RESET  = 256;
    localparam int PROD_BITS   = ROOT_BITS + GAIN_BITS;
    localparam int VOL_BITS    = 23;
    localparam int GAIN_SHIFT  = 8;
    localparam int ITER_BITS   = $clog2(SUM_BITS);
    localparam int PC_BITS     = 4;
    localparam int IN_BYTES    = (SAMPLE_BITS + 7) / 8;
    localparam int OUT_BYTES   = (VOL_BITS + 7) / 8;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQUARE,
        OP_ACCUM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_SCALE,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_WAIT_IN,
        C_IF_MORE,
        C_LOOP,
        C_WAIT_OUT,
        C_GOTO
    } cond_t;

    typedef struct packed {
        op_t                op;
        cond_t              cond;
        logic [PC_BITS-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic last;
        logic iter_done;
        logic out_busy;
    } dp_status_t;

    localparam logic [PC_BITS-1:0] PC_START = PC_BITS'(0);
    localparam logic [PC_BITS-1:0] PC_DIV   = PC_BITS'(4);
    localparam logic [PC_BITS-1:0] PC_SQRT  = PC_BITS'(6);
    localparam logic [PC_BITS-1:0] PC_EMIT  = PC_BITS'(8);

    function automatic ctrl_word_t rom_word(input logic [PC_BITS-1:0] pc);
        ctrl_word_t w;
        case (pc)
            PC_BITS'(0): w = '{OP_LOAD,      C_WAIT_IN,  PC_START};
            PC_BITS'(1): w = '{OP_SQUARE,    C_NEXT,     PC_START};
            PC_BITS'(2): w = '{OP_ACCUM,     C_IF_MORE,  PC_START};
            PC_BITS'(3): w = '{OP_DIV_INIT,  C_NEXT,     PC_START};
            PC_BITS'(4): w = '{OP_DIV_STEP,  C_LOOP,     PC_DIV};
            PC_BITS'(5): w = '{OP_SQRT_INIT, C_NEXT,     PC_START};
            PC_BITS'(6): w = '{OP_SQRT_STEP, C_LOOP,     PC_SQRT};
            PC_BITS'(7): w = '{OP_SCALE,     C_NEXT,     PC_START};
            PC_BITS'(8): w = '{OP_EMIT,      C_WAIT_OUT, PC_START};
            default:     w = '{OP_NOP,       C_GOTO,     PC_START};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/rlm_sequencer.sv =====
// Microcode sequencer of the RMS level meter: step counter, control ROM
// lookup and conditional jumps. Depends on rlm_pkg.
module rlm_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  rlm_pkg::dp_status_t status,
    output rlm_pkg::ctrl_word_t ctrl
);
    import rlm_pkg::*;

    logic [PC_BITS-1:0] pc_reg;
    logic [PC_BITS-1:0] pc_next;
    logic [PC_BITS-1:0] pc_inc;

    assign ctrl   = rom_word(pc_reg);
    assign pc_inc = pc_reg + PC_BITS'(1);

    always_comb begin
        case (ctrl.cond)
            C_NEXT:     pc_next = pc_inc;
            C_WAIT_IN:  pc_next = s_tvalid ? pc_inc : pc_reg;
            C_IF_MORE:  pc_next = status.last ? pc_inc : ctrl.target;
            C_LOOP:     pc_next = status.iter_done ? pc_inc : ctrl.target;
            C_WAIT_OUT: pc_next = status.out_busy ? pc_reg : ctrl.target;
            C_GOTO:     pc_next = ctrl.target;
            default:    pc_next = PC_START;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_START;
        end else begin
            pc_reg <= pc_next;
        end
    end

`ifndef SYNTHESIS
    a_loop_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.cond == C_LOOP && !status.iter_done) |=> $stable(pc_reg))
        else $error("sequencer left a loop before its count ran out");
    a_wait_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_LOAD && !s_tvalid) |=> (ctrl.op == OP_LOAD))
        else $error("sequencer left the load step without a beat");
    a_emit_to_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_EMIT && !status.out_busy) |=> (pc_reg == PC_START))
        else $error("sequencer did not return to the start after a result");
`endif

endmodule

// ===== sv/rlm_datapath.sv =====
// Datapath of the RMS level meter: squarer, saturating accumulator, shared
// one-bit divider and square-root shift registers, gain multiplier and the
// result register. Driven by the control word; depends on rlm_pkg.
module rlm_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rlm_pkg::ctrl_word_t                ctrl,
    input  logic [rlm_pkg::GAIN_BITS-1:0]      gain,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rlm_pkg::IN_BYTES*8-1:0]     s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rlm_pkg::OUT_BYTES*8-1:0]    m_tdata,
    output rlm_pkg::dp_status_t                status
);
    import rlm_pkg::*;

    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                          last_reg, last_next;
    logic [SQ_BITS-1:0]            sq_reg, sq_next;
    logic [SUM_BITS-1:0]           sum_reg, sum_next;
    logic [CNT_BITS-1:0]           count_reg, count_next;
    logic [SUM_BITS-1:0]           div_reg, div_next;
    logic [CNT_BITS-1:0]           rem_reg, rem_next;
    logic [SREM_BITS-1:0]          sr_reg, sr_next;
    logic [ROOT_BITS-1:0]          root_reg, root_next;
    logic [ITER_BITS-1:0]          iter_reg, iter_next;
    logic [PROD_BITS-1:0]          prod_reg, prod_next;
    logic [VOL_BITS-1:0]           vol_reg, vol_next;
    logic                          out_valid_reg, out_valid_next;

    logic [SAMPLE_BITS-1:0]        mag;
    logic [SUM_BITS:0]             sum_wide;
    logic [CNT_BITS:0]             div_trial;
    logic                          div_ge;
    logic [SREM_BITS+1:0]          sqrt_rem;
    logic [SREM_BITS+1:0]          sqrt_trial;
    logic                          sqrt_ge;
    logic [PROD_BITS-GAIN_SHIFT-1:0] scaled;
    logic                          out_busy;
    logic                          emit_fire;

    assign s_tready = (ctrl.op == OP_LOAD);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_BYTES*8-VOL_BITS){1'b0}}, vol_reg};
    assign out_busy = out_valid_reg && !m_tready;
    assign emit_fire = (ctrl.op == OP_EMIT) && !out_busy;

    assign status.last      = last_reg;
    assign status.iter_done = (iter_reg == '0);
    assign status.out_busy  = out_busy;

    assign mag = sample_reg[SAMPLE_BITS-1] ? (~sample_reg + SAMPLE_BITS'(1))
                                           : sample_reg;
    assign sum_wide  = {1'b0, sum_reg} + (SUM_BITS+1)'(sq_reg);
    assign div_trial = {rem_reg, div_reg[SUM_BITS-1]};
    assign div_ge    = (div_trial >= {1'b0, count_reg});
    assign sqrt_rem  = {sr_reg, div_reg[SUM_BITS-1 -: 2]};
    assign sqrt_trial = {1'b0, root_reg, 2'b01};
    assign sqrt_ge   = (sqrt_rem >= sqrt_trial);
    assign scaled    = prod_reg[PROD_BITS-1:GAIN_SHIFT];

    always_comb begin
        sample_next    = sample_reg;
        last_next      = last_reg;
        sq_next        = sq_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        sr_next        = sr_reg;
        root_next      = root_reg;
        iter_next      = iter_reg;
        prod_next      = prod_reg;
        vol_next       = vol_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (ctrl.op)
            OP_LOAD: begin
                if (s_tvalid) begin
                    sample_next = s_tdata[SAMPLE_BITS-1:0];
                    last_next   = s_tlast;
                end
            end
            OP_SQUARE: begin
                sq_next = SQ_BITS'(mag) * SQ_BITS'(mag);
            end
            OP_ACCUM: begin
                if (count_reg < CNT_BITS'(MAX_FRAME)) begin
                    sum_next   = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
                    count_next = count_reg + CNT_BITS'(1);
                end
            end
            OP_DIV_INIT: begin
                div_next  = sum_reg;
                rem_next  = '0;
                iter_next = ITER_BITS'(SUM_BITS - 1);
            end
            OP_DIV_STEP: begin
                rem_next  = div_ge ? CNT_BITS'(div_trial - {1'b0, count_reg})
                                   : div_trial[CNT_BITS-1:0];
                div_next  = {div_reg[SUM_BITS-2:0], div_ge};
                iter_next = iter_reg - ITER_BITS'(1);
            end
            OP_SQRT_INIT: begin
                sr_next   = '0;
                root_next = '0;
                iter_next = ITER_BITS'(ROOT_BITS - 1);
            end
            OP_SQRT_STEP: begin
                sr_next   = sqrt_ge ? SREM_BITS'(sqrt_rem - sqrt_trial)
                                    : sqrt_rem[SREM_BITS-1:0];
                root_next = {root_reg[ROOT_BITS-2:0], sqrt_ge};
                div_next  = {div_reg[SUM_BITS-3:0], 2'b00};
                iter_next = iter_reg - ITER_BITS'(1);
            end
            OP_SCALE: begin
                prod_next = PROD_BITS'(root_reg) * PROD_BITS'(gain);
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    if (count_reg == '0) begin
                        vol_next = '0;
                    end else if (|scaled[PROD_BITS-GAIN_SHIFT-1:VOL_BITS]) begin
                        vol_next = '1;
                    end else begin
                        vol_next = scaled[VOL_BITS-1:0];
                    end
                    out_valid_next = 1'b1;
                    sum_next       = '0;
                    count_next     = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            count_reg     <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        last_reg   <= last_next;
        sq_reg     <= sq_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        sr_reg     <= sr_next;
        root_reg   <= root_next;
        prod_reg   <= prod_next;
        vol_reg    <= vol_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(MAX_FRAME))
        else $error("frame sample count ran past the frame limit");
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_DIV_STEP && count_reg != '0) |=> (rem_reg < count_reg))
        else $error("divider remainder not below the divisor");
    a_sqrt_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_SQRT_STEP) |=> (sr_reg <= {root_reg, 1'b0}))
        else $error("square-root remainder exceeds twice the partial root");
    a_emit_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |=> (m_tvalid && sum_reg == '0 && count_reg == '0))
        else $error("result beat not raised or frame not cleared");
`endif

endmodule

// ===== sv/block_rms_level_meter_unit.sv =====
// Top level of the RMS level meter: gain register and configuration port,
// with the microcode sequencer and datapath. Depends on rlm_pkg,
// rlm_sequencer and rlm_datapath.
//
// Usage: audio samples enter as beats on the s_ channel, one signed Q1.15
// sample per beat, with s_tlast set on the last sample of a frame. On each
// frame's last beat the block emits one m_ beat holding the frame's RMS
// scaled by the Q8.8 gain and truncated, in Q0.15 units; other beats give
// no result. Up to 4096 samples of a frame are counted; later ones are
// ignored until s_tlast. cfg_ready is always high; the user must write the
// gain on the cfg_ channel while the block is idle; this is not enforced.
// A sample that does not close a frame passes the load, square and accumulate
// steps of the microprogram before the next one is taken. A closing sample
// then passes the divider setup, 42 one-bit divider steps, the square-root
// setup, 21 square-root steps, the scale step and the emit step, which
// raises m_tvalid; only after that is the next sample taken.
// Reset clears the accumulated sum and count, drops m_tvalid and restores
// unity gain. While the receiver stalls, the result holds in the output
// register and samples keep being accepted; only the next frame's result
// step waits for the pending beat to be taken.
module block_rms_level_meter_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rlm_pkg::GAIN_BITS-1:0]      cfg_data,    // gain[15:0]
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rlm_pkg::IN_BYTES*8-1:0]     s_tdata,     // sample[15:0]
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rlm_pkg::OUT_BYTES*8-1:0]    m_tdata      // volume[22:0], zero[23]
);
    import rlm_pkg::*;

    logic [GAIN_BITS-1:0] gain_reg;
    logic [GAIN_BITS-1:0] gain_next;
    ctrl_word_t           ctrl;
    dp_status_t           status;

    assign cfg_ready = 1'b1;
    assign gain_next = (cfg_valid && cfg_ready) ? cfg_data : gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_BITS'(GAIN_RESET);
        end else begin
            gain_reg <= gain_next;
        end
    end

    rlm_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .ctrl     (ctrl)
    );

    rlm_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .gain     (gain_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .status   (status)
    );

endmodule
